### sv/mat4_pkg.sv
// Shared types, constants and fixed-point helpers for the 4x4 matrix unit.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package mat4_pkg;

    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = 2;
    localparam int CELLS     = DIM * DIM;
    localparam int CELL_W    = $clog2(CELLS);
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = DATA_W + $clog2(DIM) + 1;

    typedef enum logic [1:0] {
        FUNC_MUL = 2'd0,
        FUNC_ADD = 2'd1,
        FUNC_SUB = 2'd2,
        FUNC_CMP = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             store;
        logic             issue;
        logic             acc_clr;
        logic             emit;
        func_t            func;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] k;
    } dp_cmd_t;

    typedef struct packed {
        logic out_ready;
    } dp_sts_t;

    function automatic logic [CELL_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        cell_addr = CELL_W'(int'(r) * DIM + int'(c));
    endfunction

    // Floor shift of a full product, saturated to the 32-bit signed range.
    function automatic logic signed [DATA_W-1:0] sat_prod(
        input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] sh;
        sh = p >>> FRAC_BITS;
        if ((&sh[PROD_W-1:DATA_W-1]) || !(|sh[PROD_W-1:DATA_W-1]))
            sat_prod = sh[DATA_W-1:0];
        else if (sh[PROD_W-1])
            sat_prod = {1'b1, {(DATA_W-1){1'b0}}};
        else
            sat_prod = {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_acc(
        input logic signed [ACC_W-1:0] v);
        if ((&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1]))
            sat_acc = v[DATA_W-1:0];
        else if (v[ACC_W-1])
            sat_acc = {1'b1, {(DATA_W-1){1'b0}}};
        else
            sat_acc = {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

endpackage

`default_nettype wire

### sv/mat4_ctrl.sv
// Sequencer for the 4x4 matrix unit: input handshake, element walk and MAC steps.
// Depends on mat4_pkg; drives the datapath through mat4_pkg::dp_cmd_t.
`default_nettype none

module mat4_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [1:0]                func,
    input  wire logic                      go,
    input  wire mat4_pkg::dp_sts_t         sts,
    output mat4_pkg::dp_cmd_t              cmd
);

    mat4_pkg::state_t                   state_reg, state_next;
    mat4_pkg::func_t                    func_reg, func_next;
    logic [mat4_pkg::IDX_W-1:0]         row_reg, row_next;
    logic [mat4_pkg::IDX_W-1:0]         col_reg, col_next;
    logic [mat4_pkg::IDX_W-1:0]         k_reg, k_next;
    logic                               accept;
    logic                               at_end;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= mat4_pkg::ST_IDLE;
            func_reg  <= mat4_pkg::FUNC_MUL;
            row_reg   <= '0;
            col_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            func_reg  <= func_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        func_next   = func_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        k_next      = k_reg;
        in_stall    = 1'b1;
        accept      = 1'b0;
        at_end      = (int'(row_reg) == mat4_pkg::DIM - 1)
                      && (int'(col_reg) == mat4_pkg::DIM - 1);
        cmd         = '0;
        cmd.func    = func_reg;
        cmd.row     = row_reg;
        cmd.col     = col_reg;
        cmd.k       = k_reg;

        unique case (state_reg)
            mat4_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                accept    = in_valid;
                cmd.store = accept;
                if (accept && go)
                begin
                    func_next = mat4_pkg::func_t'(func);
                    row_next  = '0;
                    col_next  = '0;
                    k_next    = '0;
                    if (mat4_pkg::func_t'(func) == mat4_pkg::FUNC_MUL)
                        state_next = mat4_pkg::ST_MUL;
                    else
                        state_next = mat4_pkg::ST_EMIT;
                end
            end
            mat4_pkg::ST_MUL:
            begin
                cmd.issue   = 1'b1;
                cmd.acc_clr = (k_reg == '0);
                k_next      = k_reg + 1'b1;
                if (int'(k_reg) == mat4_pkg::DIM - 1)
                    state_next = mat4_pkg::ST_DRAIN;
            end
            mat4_pkg::ST_DRAIN:
            begin
                state_next = mat4_pkg::ST_EMIT;
            end
            mat4_pkg::ST_EMIT:
            begin
                if (sts.out_ready)
                begin
                    cmd.emit = 1'b1;
                    k_next   = '0;
                    if (func_reg == mat4_pkg::FUNC_CMP || at_end)
                    begin
                        state_next = mat4_pkg::ST_IDLE;
                    end
                    else
                    begin
                        if (int'(col_reg) == mat4_pkg::DIM - 1)
                        begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                        if (func_reg == mat4_pkg::FUNC_MUL)
                            state_next = mat4_pkg::ST_MUL;
                    end
                end
            end
            default:
            begin
                state_next = mat4_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/mat4_dp.sv
// Datapath of the 4x4 matrix unit: matrix storage, multiply-accumulate,
// add/subtract/compare and the output register. Depends on mat4_pkg.
`default_nettype none

module mat4_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire mat4_pkg::dp_cmd_t                   cmd,
    output mat4_pkg::dp_sts_t                        sts,
    input  wire logic                                operand,
    input  wire logic [mat4_pkg::IDX_W-1:0]          row,
    input  wire logic [mat4_pkg::IDX_W-1:0]          col,
    input  wire logic signed [mat4_pkg::DATA_W-1:0]  element_value,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [mat4_pkg::IDX_W-1:0]               out_row,
    output logic [mat4_pkg::IDX_W-1:0]               out_col,
    output logic signed [mat4_pkg::DATA_W-1:0]       out_value,
    output logic                                     equal,
    output logic                                     last
);

    logic signed [mat4_pkg::DATA_W-1:0] left_mem_reg  [mat4_pkg::CELLS];
    logic signed [mat4_pkg::DATA_W-1:0] right_mem_reg [mat4_pkg::CELLS];
    logic [mat4_pkg::CELL_W-1:0]        left_addr, right_addr, wr_addr;
    logic signed [mat4_pkg::DATA_W-1:0] left_q, right_q;
    logic signed [mat4_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                               prod_vld_reg;
    logic signed [mat4_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic                               wr_ok;
    logic                               all_eq;
    logic signed [mat4_pkg::DATA_W-1:0] res_value;
    logic                               res_last;
    logic                               out_load;

    logic                               out_valid_reg;
    logic [mat4_pkg::IDX_W-1:0]         out_row_reg, out_col_reg;
    logic signed [mat4_pkg::DATA_W-1:0] out_value_reg;
    logic                               equal_reg, last_reg;

    assign wr_addr = mat4_pkg::cell_addr(row, col);
    assign wr_ok   = (int'(row) < mat4_pkg::DIM) && (int'(col) < mat4_pkg::DIM);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            for (int i = 0; i < mat4_pkg::CELLS; i++)
            begin
                left_mem_reg[i]  <= '0;
                right_mem_reg[i] <= '0;
            end
        end
        else if (cmd.store && wr_ok)
        begin
            if (operand)
                right_mem_reg[wr_addr] <= element_value;
            else
                left_mem_reg[wr_addr] <= element_value;
        end
    end

    always_comb begin
        if (cmd.func == mat4_pkg::FUNC_MUL)
        begin
            left_addr  = mat4_pkg::cell_addr(cmd.row, cmd.k);
            right_addr = mat4_pkg::cell_addr(cmd.k, cmd.col);
        end
        else
        begin
            left_addr  = mat4_pkg::cell_addr(cmd.row, cmd.col);
            right_addr = left_addr;
        end
    end

    assign left_q    = left_mem_reg[left_addr];
    assign right_q   = right_mem_reg[right_addr];
    assign prod_next = left_q * right_q;

    always_ff @(posedge clk) begin
        prod_reg <= prod_next;
    end

    always_comb begin
        if (cmd.acc_clr)
            acc_next = '0;
        else if (prod_vld_reg)
            acc_next = acc_reg + mat4_pkg::ACC_W'(mat4_pkg::sat_prod(prod_reg));
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= cmd.issue;
            acc_reg      <= acc_next;
        end
    end

    always_comb begin
        all_eq = 1'b1;
        for (int i = 0; i < mat4_pkg::CELLS; i++)
        begin
            if (left_mem_reg[i] != right_mem_reg[i])
                all_eq = 1'b0;
        end
    end

    always_comb begin
        res_last = (int'(cmd.row) == mat4_pkg::DIM - 1)
                   && (int'(cmd.col) == mat4_pkg::DIM - 1);
        unique case (cmd.func)
            mat4_pkg::FUNC_MUL: res_value = mat4_pkg::sat_acc(acc_reg);
            mat4_pkg::FUNC_ADD: res_value = mat4_pkg::sat_acc(
                                    mat4_pkg::ACC_W'(left_q) + mat4_pkg::ACC_W'(right_q));
            mat4_pkg::FUNC_SUB: res_value = mat4_pkg::sat_acc(
                                    mat4_pkg::ACC_W'(left_q) - mat4_pkg::ACC_W'(right_q));
            default:            res_value = '0;
        endcase
    end

    assign sts.out_ready = !out_valid_reg || !out_stall;
    assign out_load      = cmd.emit && sts.out_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk) begin
        if (out_load)
        begin
            if (cmd.func == mat4_pkg::FUNC_CMP)
            begin
                out_row_reg   <= '0;
                out_col_reg   <= '0;
                out_value_reg <= '0;
                equal_reg     <= all_eq;
                last_reg      <= 1'b1;
            end
            else
            begin
                out_row_reg   <= cmd.row;
                out_col_reg   <= cmd.col;
                out_value_reg <= res_value;
                equal_reg     <= 1'b0;
                last_reg      <= res_last;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign equal     = equal_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

### sv/matrix4_multiply_add_compare.sv
// Top level of the 4x4 signed Q16.16 matrix unit.
// Instantiates mat4_ctrl and mat4_dp; depends on mat4_pkg.
//
// Usage: each input transaction (in_valid high, in_stall low) stores one
// element into the left (operand 0) or right (operand 1) matrix at row/col.
// A transaction with go set then runs func on the stored matrices:
// multiply, add or subtract emit sixteen output transactions in row-major
// order with last on the final one; compare emits one transaction whose
// equal flag tells whether all sixteen pairs match.
// Sequencing: an element load without go is taken in the idle state. A
// multiply result takes four issue steps of the single shared multiplier,
// one accumulate drain step and one load of the output register. Add and
// subtract load results back to back, compare a single one; out_stall can
// hold either. The first result is registered from ST_EMIT, entered straight
// from the go transaction for add/subtract/compare and via ST_MUL and
// ST_DRAIN for multiply. in_stall is high while a run is in progress.
// Reset clears both matrices to zero and empties the output register.
// When out_stall is held, the output register keeps its transaction and
// the run waits; a new input is taken once the last result is registered.
`default_nettype none

module matrix4_multiply_add_compare (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [1:0]                          func,
    input  wire logic                                operand,
    input  wire logic [mat4_pkg::IDX_W-1:0]          row,
    input  wire logic [mat4_pkg::IDX_W-1:0]          col,
    input  wire logic signed [mat4_pkg::DATA_W-1:0]  element_value,
    input  wire logic                                go,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [mat4_pkg::IDX_W-1:0]               out_row,
    output logic [mat4_pkg::IDX_W-1:0]               out_col,
    output logic signed [mat4_pkg::DATA_W-1:0]       out_value,
    output logic                                     equal,
    output logic                                     last
);

    mat4_pkg::dp_cmd_t cmd;
    mat4_pkg::dp_sts_t sts;

    mat4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .go       (go),
        .sts      (sts),
        .cmd      (cmd)
    );

    mat4_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .operand       (operand),
        .row           (row),
        .col           (col),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_row       (out_row),
        .out_col       (out_col),
        .out_value     (out_value),
        .equal         (equal),
        .last          (last)
    );

endmodule

`default_nettype wire
